// ===== sv/lcp_pkg.sv =====
// ----------------------------------------------------------------------------
// lcp_pkg: shared definitions for the LRU cache with pinning
// Action, status and register codes, defaults and saturating size helpers.
// ----------------------------------------------------------------------------
package lcp_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int LOCK_BITS_DEF = 8;
    localparam logic [31:0] BUDGET_RESET = 32'd128;

    typedef enum logic [2:0] {
        ACT_ACCESS  = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_LOCK    = 3'd2,
        ACT_UNLOCK  = 3'd3,
        ACT_RESIZE  = 3'd4
    } t_action;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NOSLOT  = 2'd2;

    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_MAX    = 1'b1;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? (a - b) : 32'd0;
    endfunction

endpackage

// ===== sv/lcp_ram.sv =====
// ----------------------------------------------------------------------------
// lcp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== sv/lru_cache_with_pinning_unit.sv =====
// ----------------------------------------------------------------------------
// lru_cache_with_pinning_unit: LRU table of keyed entries with lock counts
// Entries live in one RAM; operations work by chains of sweeps over it.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command item (tuser = action). m_axis returns one
//   item per evicted entry (tuser = 1) followed by a closing item with
//   tlast set that carries hit, lock state and status. The cfg channel
//   writes size_budget (index 0) or max_entries (index 1); it is always
//   ready; the user writes it only while the unit is idle (not enforced).
// Timing:
//   Items are handled one at a time. Each RAM sweep issues one read per
//   cycle for every entry, then handles the registered read data and closes.
//   A lookup item takes one sweep for the key search plus, on a hit that
//   changes the table, one update sweep. Each eviction step adds a find
//   sweep and, when the entry is dropped, a rank update sweep; a miss
//   adds an insert sweep. Output stalls add to the time taken.
// Reset:
//   Synchronous, active low; all valid bits, size total and count clear,
//   budget returns to 128, limit to 0. RAM contents are not cleared.
// Stall:
//   A result waits in the output register; the unit holds until it goes.
// ----------------------------------------------------------------------------
module lru_cache_with_pinning_unit
    import lcp_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int LOCK_BITS = LOCK_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: key[31:0], active[32], load_size[48:33], size_change[64:49]
    input  logic [71:0] s_axis_tdata,
    // tuser: action[2:0]
    input  logic [2:0]  s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: evicted_key[31:0], hit[32], is_locked[33], status[35:34]
    output logic [39:0] m_axis_tdata,
    // tuser: is_eviction[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int SW   = IW + 1;
    localparam int CMPW = ((CW > 5) ? CW : 5) + 1;
    localparam int WW   = 48 + LOCK_BITS + IW;
    localparam logic [LOCK_BITS-1:0] LOCK_MAX = {LOCK_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE, S_SWEEP, S_DISPATCH, S_EVAL, S_EMIT, S_INS, S_FIN
    } t_state;

    typedef enum logic [2:0] {
        K_SEARCH, K_FIND, K_MOVE, K_DROP, K_INSERT, K_LOCK
    } t_kind;

    t_state r_state;
    t_kind  r_kind;

    // latched command
    logic [2:0]  r_action;
    logic [31:0] r_key;
    logic        r_active;
    logic [15:0] r_load;
    logic [15:0] r_delta;

    // table-wide state
    logic [ENTRIES-1:0] r_valid;
    logic [31:0]        r_total;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_budget;
    logic [4:0]         r_max;

    // sweep control
    logic [SW-1:0] r_scnt;
    logic          r_pvld;
    logic [IW-1:0] r_pidx;

    // entry found by the last search or find sweep
    logic                 r_found;
    logic [IW-1:0]        r_fidx;
    logic [IW-1:0]        r_frank;
    logic [LOCK_BITS-1:0] r_flock;
    logic [15:0]          r_fsize;
    logic [31:0]          r_fkey;

    // eviction pass
    logic          r_in_pass;
    logic          r_reserve;
    logic [CW-1:0] r_skip;
    logic [IW-1:0] r_trank;

    // closing result
    logic       r_hit;
    logic       r_locked;
    logic [1:0] r_status;

    // output register
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_user;
    logic        r_out_last;

    // RAM ports
    logic [WW-1:0] rdata, wdata;
    logic          we;

    logic [31:0]          rd_key;
    logic [15:0]          rd_size;
    logic [LOCK_BITS-1:0] rd_lock;
    logic [IW-1:0]        rd_rank;
    logic [IW-1:0]        w_rank;
    logic [LOCK_BITS-1:0] w_lock;
    logic [15:0]          w_size;
    logic [31:0]          w_key;

    logic          issue, sweep_done, pv, out_free, over, out_load;
    logic          free_any;
    logic [IW-1:0] free_idx;
    logic [LOCK_BITS-1:0] lock_up, lock_dn;
    logic [15:0]   delta_mag;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    assign {rd_rank, rd_lock, rd_size, rd_key} = rdata;
    assign wdata = {w_rank, w_lock, w_size, w_key};

    assign issue      = (r_state == S_SWEEP) && (r_scnt < SW'(ENTRIES));
    assign sweep_done = (r_state == S_SWEEP) && (r_scnt == SW'(ENTRIES)) && !r_pvld;
    assign pv         = r_pvld && r_valid[r_pidx];
    assign out_free   = !r_out_valid || m_axis_tready;
    // output register reloads this cycle
    assign out_load   = ((r_state == S_EMIT) || (r_state == S_FIN)) && out_free;

    // eviction keeps going while at or over budget or at the count limit
    assign over = (r_total >= r_budget) ||
                  ((r_max != 5'd0) &&
                   ((CMPW'(r_count) + CMPW'(r_reserve)) >= CMPW'(r_max)));

    assign lock_up   = (r_flock == LOCK_MAX) ? r_flock : r_flock + 1'b1;
    assign lock_dn   = (r_flock == '0) ? r_flock : r_flock - 1'b1;
    assign delta_mag = ~r_delta + 16'd1;

    lcp_ram #(.WIDTH(WW), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pidx),
        .i_wdata (wdata),
        .i_raddr (r_scnt[IW-1:0]),
        .o_rdata (rdata)
    );

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // read-modify-write of the entry just read
    always_comb begin
        we     = 1'b0;
        w_rank = rd_rank;
        w_lock = rd_lock;
        w_size = rd_size;
        w_key  = rd_key;
        unique case (r_kind)
            K_SEARCH, K_FIND: begin
                we = 1'b0;
            end
            K_MOVE: begin
                we = pv;
                if (r_pidx == r_fidx) begin
                    w_rank = '0;
                end else if (rd_rank < r_frank) begin
                    w_rank = rd_rank + 1'b1;
                end
            end
            K_DROP: begin
                we     = pv && (rd_rank > r_frank);
                w_rank = rd_rank - 1'b1;
            end
            K_INSERT: begin
                if (r_pvld && (r_pidx == r_fidx)) begin
                    we     = 1'b1;
                    w_rank = '0;
                    w_lock = '0;
                    w_size = r_load;
                    w_key  = r_key;
                end else begin
                    we     = pv;
                    w_rank = rd_rank + 1'b1;
                end
            end
            K_LOCK: begin
                we     = r_pvld && (r_pidx == r_fidx);
                w_lock = r_flock;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_SEARCH;
            r_valid     <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_budget    <= BUDGET_RESET;
            r_max       <= '0;
            r_scnt      <= '0;
            r_pvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BUDGET: r_budget <= i_cfg_data;
                    CFG_MAX:    r_max    <= i_cfg_data[4:0];
                endcase
            end

            if (r_out_valid && m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_action  <= s_axis_tuser;
                        r_key     <= s_axis_tdata[31:0];
                        r_active  <= s_axis_tdata[32];
                        r_load    <= s_axis_tdata[48:33];
                        r_delta   <= s_axis_tdata[64:49];
                        r_hit     <= 1'b0;
                        r_locked  <= 1'b0;
                        r_status  <= ST_IGNORED;
                        r_skip    <= '0;
                        r_in_pass <= 1'b0;
                        r_reserve <= 1'b0;
                        if (s_axis_tuser <= ACT_UNLOCK) begin
                            r_kind  <= K_SEARCH;
                            r_scnt  <= '0;
                            r_pvld  <= 1'b0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_DISPATCH;
                        end
                    end
                end

                S_SWEEP: begin
                    if (issue) begin
                        r_scnt <= r_scnt + 1'b1;
                    end
                    r_pvld <= issue;
                    r_pidx <= r_scnt[IW-1:0];
                    if (pv && (((r_kind == K_SEARCH) && (rd_key == r_key)) ||
                               ((r_kind == K_FIND) && (rd_rank == r_trank)))) begin
                        r_hit   <= (r_kind == K_SEARCH) ? 1'b1 : r_hit;
                        r_found <= 1'b1;
                        r_fidx  <= r_pidx;
                        r_frank <= rd_rank;
                        r_flock <= rd_lock;
                        r_fsize <= rd_size;
                        r_fkey  <= rd_key;
                    end
                    if (sweep_done) begin
                        unique case (r_kind)
                            K_SEARCH: r_state <= S_DISPATCH;
                            K_FIND: begin
                                if (!r_found) begin
                                    r_state <= (r_action == ACT_ACCESS) ? S_INS : S_FIN;
                                end else if (r_flock == '0) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_skip  <= r_skip + 1'b1;
                                    r_state <= S_EVAL;
                                end
                            end
                            K_DROP:  r_state <= r_in_pass ? S_EVAL : S_FIN;
                            K_MOVE, K_INSERT, K_LOCK: r_state <= S_FIN;
                            default: r_state <= S_FIN;
                        endcase
                    end
                end

                S_DISPATCH: begin
                    // lock state after the step, unless changed below
                    r_locked <= r_hit && (r_flock != '0);
                    r_scnt   <= '0;
                    r_pvld   <= 1'b0;
                    unique case (r_action)
                        ACT_ACCESS: begin
                            if (!r_active) begin
                                r_state <= S_FIN;
                            end else if (r_hit) begin
                                r_status <= ST_DONE;
                                r_kind   <= K_MOVE;
                                r_state  <= S_SWEEP;
                            end else begin
                                r_in_pass <= 1'b1;
                                r_reserve <= (r_max != 5'd0);
                                r_state   <= S_EVAL;
                            end
                        end
                        ACT_RELEASE: begin
                            if (r_active && r_hit && (r_flock == '0)) begin
                                r_status <= ST_DONE;
                                r_fkey   <= r_key;
                                r_locked <= 1'b0;
                                r_state  <= S_EMIT;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        ACT_LOCK, ACT_UNLOCK: begin
                            if (r_hit) begin
                                r_status <= ST_DONE;
                                r_flock  <= (r_action == ACT_LOCK) ? lock_up : lock_dn;
                                r_locked <= (r_action == ACT_LOCK) ? (lock_up != '0)
                                                                   : (lock_dn != '0);
                                r_kind   <= K_LOCK;
                                r_state  <= S_SWEEP;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        ACT_RESIZE: begin
                            r_total   <= r_delta[15] ? sat_sub32(r_total, 32'(delta_mag))
                                                     : sat_add32(r_total, 32'(r_delta));
                            r_status  <= ST_DONE;
                            r_in_pass <= 1'b1;
                            r_state   <= S_EVAL;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end

                S_EVAL: begin
                    if (over && (r_count > r_skip)) begin
                        // oldest entry not yet skipped
                        r_trank <= IW'(r_count - 1'b1 - r_skip);
                        r_found <= 1'b0;
                        r_kind  <= K_FIND;
                        r_scnt  <= '0;
                        r_pvld  <= 1'b0;
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= (r_action == ACT_ACCESS) ? S_INS : S_FIN;
                    end
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'd0, 2'd0, 1'b0, 1'b0, r_fkey};
                        r_out_user  <= 1'b1;
                        r_out_last  <= 1'b0;
                        r_valid[r_fidx] <= 1'b0;
                        r_count <= r_count - 1'b1;
                        r_total <= sat_sub32(r_total, 32'(r_fsize));
                        r_kind  <= K_DROP;
                        r_scnt  <= '0;
                        r_pvld  <= 1'b0;
                        r_state <= S_SWEEP;
                    end
                end

                S_INS: begin
                    if (!free_any) begin
                        r_status <= ST_NOSLOT;
                        r_state  <= S_FIN;
                    end else begin
                        r_status  <= ST_DONE;
                        r_fidx    <= free_idx;
                        r_valid[free_idx] <= 1'b1;
                        r_count   <= r_count + 1'b1;
                        r_total   <= sat_add32(r_total, 32'(r_load));
                        r_kind    <= K_INSERT;
                        r_scnt    <= '0;
                        r_pvld    <= 1'b0;
                        r_state   <= S_SWEEP;
                    end
                end

                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'd0, r_status, r_locked, r_hit, 32'd0};
                        r_out_user  <= 1'b0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
